/* rtl/rac_pkg.sv */
// Shared types and constants for the region allocator.
package rac_pkg;

  localparam int MAX_BLOCKS       = 64;
  localparam int REGION_MAX_BYTES = 1048576;
  localparam int HEADER_BYTES     = 16;
  localparam int PAGE_BYTES       = 4096;
  localparam int ALIGN_BYTES      = 8;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W = 20;
  localparam int TOT_W  = 21;
  localparam int SIZE_W = 22;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_BAD   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_BAD_ARGS    = 2'd1,
    STS_NO_SPACE    = 2'd2,
    STS_BAD_POINTER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_BEST  = 2'd0,
    FIT_WORST = 2'd1,
    FIT_FIRST = 2'd2,
    FIT_OTHER = 2'd3
  } fit_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_ROT,
    CMD_INS,
    CMD_REM,
    CMD_SETF,
    CMD_LOAD
  } cell_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic              free;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  pos;
    logic [ADDR_W-1:0] start;
    logic              free;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RESOLVE,
    ST_INS,
    ST_MARK,
    ST_FMARK,
    ST_REMA,
    ST_REMB,
    ST_DONE
  } state_t;

endpackage

/* rtl/rac_cell.sv */
// One table slot: holds a block entry and trades it with its neighbors.
module rac_cell (
  input  logic                      clk,
  input  rac_pkg::cell_cmd_t        cmd,
  input  logic [rac_pkg::IDX_W-1:0] idx,
  input  rac_pkg::entry_t           left,
  input  rac_pkg::entry_t           right,
  output rac_pkg::entry_t           ent
);

  always_ff @(posedge clk) begin
    case (cmd.op)
      rac_pkg::CMD_ROT: begin
        ent <= right;
      end
      rac_pkg::CMD_INS: begin
        if (idx > cmd.pos) begin
          ent <= left;
        end else if (idx == cmd.pos) begin
          ent.start <= cmd.start;
          ent.free  <= 1'b1;
        end
      end
      rac_pkg::CMD_REM: begin
        if (idx >= cmd.pos) begin
          ent <= right;
        end
      end
      rac_pkg::CMD_SETF: begin
        if (idx == cmd.pos) begin
          ent.free <= cmd.free;
        end
      end
      rac_pkg::CMD_LOAD: begin
        if (idx == cmd.pos) begin
          ent.start <= cmd.start;
          ent.free  <= cmd.free;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/rac_chain.sv */
// Ring of table cells; exposes the head, its successor and the tail.
module rac_chain (
  input  logic               clk,
  input  rac_pkg::cell_cmd_t cmd,
  output rac_pkg::entry_t    head,
  output rac_pkg::entry_t    second,
  output rac_pkg::entry_t    tail
);

  rac_pkg::entry_t ents [rac_pkg::MAX_BLOCKS];

  for (genvar k = 0; k < rac_pkg::MAX_BLOCKS; k++) begin : g_cell
    rac_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .idx   (rac_pkg::IDX_W'(k)),
      .left  (ents[(k + rac_pkg::MAX_BLOCKS - 1) % rac_pkg::MAX_BLOCKS]),
      .right (ents[(k + 1) % rac_pkg::MAX_BLOCKS]),
      .ent   (ents[k])
    );
  end

  assign head   = ents[0];
  assign second = ents[1];
  assign tail   = ents[rac_pkg::MAX_BLOCKS-1];

endmodule

/* rtl/region_allocator_fit_coalesce_top.sv */
// Top level of the region allocator: request control and the block table ring.
//
// Manages one region as an address-ordered table of up to MAX_BLOCKS blocks held
// in a ring of cells. Init and requests that fail their argument checks skip the
// scan. Allocate and free rotate the whole ring once, one entry per cycle past
// the head cell, so the search visits every cell whatever the table fill, and a
// resolve step then settles the pick. After that an allocate may split-insert
// the leftover block and then marks busy, and a free marks free and then does
// up to two merges; the result is then posted and the block goes back to idle
// before the next request is taken. One request is worked at a time; a new
// request is taken once the previous one has been handed to the output
// register, even if that result is still waiting to be taken. Table entries
// have no reset; only entries below the block count are ever used.
module region_allocator_fit_coalesce_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // region_request[20:0], request_bytes[41:21],
                                 // payload_offset[61:42], zero pad
  input  logic [4:0]  s_tuser,   // opcode[1:0], fit_style[3:2], pointer_is_null[4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // granted_offset[19:0], zero pad
  output logic [2:0]  m_tuser    // status[1:0], granted_valid[2]
);

  rac_pkg::state_t state, state_next;
  rac_pkg::cell_cmd_t cmd;
  rac_pkg::entry_t head, second, tail;

  // Request fields held for the length of the request
  rac_pkg::opcode_t              op;
  rac_pkg::fit_t                 style;
  logic [rac_pkg::SIZE_W-1:0]    size_r;
  logic [rac_pkg::ADDR_W-1:0]    off_r;
  logic [rac_pkg::SIZE_W-1:0]    tot_round;
  logic [rac_pkg::TOT_W-1:0]     init_total;

  // Allocator state
  logic                          ready;
  logic [rac_pkg::CNT_W-1:0]     count;
  logic [rac_pkg::TOT_W-1:0]     total;

  // Scan bookkeeping
  logic [rac_pkg::IDX_W-1:0]     idx;
  logic                          found;
  logic [rac_pkg::IDX_W-1:0]     pick;
  logic [rac_pkg::ADDR_W-1:0]    pick_start;
  logic [rac_pkg::SIZE_W-1:0]    psize;
  logic                          prev_free;
  logic                          next_free;

  // Result waiting to be posted
  rac_pkg::status_t              res_status;
  logic [rac_pkg::ADDR_W-1:0]    res_offset;
  logic                          res_valid;

  logic                          accept;
  logic                          in_range;
  logic                          has_next;
  logic [rac_pkg::SIZE_W-1:0]    blk_end;
  logic [rac_pkg::SIZE_W-1:0]    blk_size;
  logic                          fit_hit;
  logic                          fit_take;
  logic                          free_hit;
  logic                          split;
  logic                          out_free;
  logic [rac_pkg::SIZE_W-1:0]    in_round8;

  rac_chain u_chain (
    .clk    (clk),
    .cmd    (cmd),
    .head   (head),
    .second (second),
    .tail   (tail)
  );

  assign s_tready = (state == rac_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Round the init size up to a page, the allocate size up to 8 bytes
  assign tot_round = ({1'b0, s_tdata[20:0]} + rac_pkg::SIZE_W'(rac_pkg::PAGE_BYTES - 1))
                     & ~rac_pkg::SIZE_W'(rac_pkg::PAGE_BYTES - 1);
  assign in_round8 = ({1'b0, s_tdata[41:21]} + rac_pkg::SIZE_W'(rac_pkg::ALIGN_BYTES - 1))
                     & ~rac_pkg::SIZE_W'(rac_pkg::ALIGN_BYTES - 1);

  // Head cell holds entry idx, its neighbor entry idx+1, the tail entry idx-1
  assign in_range = {1'b0, idx} < count;
  assign has_next = ({1'b0, idx} + rac_pkg::CNT_W'(1)) < count;
  assign blk_end  = has_next ? rac_pkg::SIZE_W'(second.start) : rac_pkg::SIZE_W'(total);
  assign blk_size = blk_end - rac_pkg::SIZE_W'(head.start)
                    - rac_pkg::SIZE_W'(rac_pkg::HEADER_BYTES);
  assign fit_hit  = in_range && head.free && (blk_size >= size_r);
  assign fit_take = fit_hit && (!found
                    || (style == rac_pkg::FIT_BEST  && blk_size < psize)
                    || (style == rac_pkg::FIT_WORST && blk_size > psize));
  assign free_hit = in_range && !head.free && !found
                    && (rac_pkg::TOT_W'(head.start) + rac_pkg::TOT_W'(rac_pkg::HEADER_BYTES)
                        == {1'b0, off_r});
  assign split    = ((psize - size_r) > rac_pkg::SIZE_W'(rac_pkg::HEADER_BYTES))
                    && (count < rac_pkg::CNT_W'(rac_pkg::MAX_BLOCKS));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rac_pkg::ST_IDLE: begin
        if (accept) begin
          case (rac_pkg::opcode_t'(s_tuser[1:0]))
            rac_pkg::OP_INIT: begin
              if (s_tdata[20:0] == '0 || ready
                  || tot_round > rac_pkg::SIZE_W'(rac_pkg::REGION_MAX_BYTES)) begin
                state_next = rac_pkg::ST_DONE;
              end else begin
                state_next = rac_pkg::ST_INIT;
              end
            end
            rac_pkg::OP_ALLOC: begin
              state_next = ready ? rac_pkg::ST_SCAN : rac_pkg::ST_DONE;
            end
            rac_pkg::OP_FREE: begin
              state_next = (ready && !s_tuser[4]) ? rac_pkg::ST_SCAN : rac_pkg::ST_DONE;
            end
            default: begin
              state_next = rac_pkg::ST_DONE;
            end
          endcase
        end
      end
      rac_pkg::ST_INIT: begin
        state_next = rac_pkg::ST_DONE;
      end
      rac_pkg::ST_SCAN: begin
        if (idx == rac_pkg::IDX_W'(rac_pkg::MAX_BLOCKS - 1)) begin
          state_next = rac_pkg::ST_RESOLVE;
        end
      end
      rac_pkg::ST_RESOLVE: begin
        if (!found) begin
          state_next = rac_pkg::ST_DONE;
        end else if (op == rac_pkg::OP_ALLOC) begin
          state_next = split ? rac_pkg::ST_INS : rac_pkg::ST_MARK;
        end else begin
          state_next = rac_pkg::ST_FMARK;
        end
      end
      rac_pkg::ST_INS: begin
        state_next = rac_pkg::ST_MARK;
      end
      rac_pkg::ST_MARK: begin
        state_next = rac_pkg::ST_DONE;
      end
      rac_pkg::ST_FMARK: begin
        if (prev_free) begin
          state_next = rac_pkg::ST_REMA;
        end else if (next_free) begin
          state_next = rac_pkg::ST_REMB;
        end else begin
          state_next = rac_pkg::ST_DONE;
        end
      end
      rac_pkg::ST_REMA: begin
        state_next = next_free ? rac_pkg::ST_REMB : rac_pkg::ST_DONE;
      end
      rac_pkg::ST_REMB: begin
        state_next = rac_pkg::ST_DONE;
      end
      rac_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = rac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rac_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the cell ring
  always_comb begin
    cmd.op    = rac_pkg::CMD_HOLD;
    cmd.pos   = '0;
    cmd.start = '0;
    cmd.free  = 1'b0;
    case (state)
      rac_pkg::ST_INIT: begin
        cmd.op   = rac_pkg::CMD_LOAD;
        cmd.free = 1'b1;
      end
      rac_pkg::ST_SCAN: begin
        cmd.op = rac_pkg::CMD_ROT;
      end
      rac_pkg::ST_INS: begin
        // Open a slot after the pick and place the leftover free block there
        cmd.op    = rac_pkg::CMD_INS;
        cmd.pos   = pick + rac_pkg::IDX_W'(1);
        cmd.start = rac_pkg::ADDR_W'(rac_pkg::SIZE_W'(pick_start)
                    + rac_pkg::SIZE_W'(rac_pkg::HEADER_BYTES) + size_r);
      end
      rac_pkg::ST_MARK: begin
        cmd.op  = rac_pkg::CMD_SETF;
        cmd.pos = pick;
      end
      rac_pkg::ST_FMARK: begin
        cmd.op   = rac_pkg::CMD_SETF;
        cmd.pos  = pick;
        cmd.free = 1'b1;
      end
      rac_pkg::ST_REMA: begin
        // Merge into the free block before: drop the freed entry
        cmd.op  = rac_pkg::CMD_REM;
        cmd.pos = pick;
      end
      rac_pkg::ST_REMB: begin
        // Drop the free block after; it slid down if the first merge happened
        cmd.op  = rac_pkg::CMD_REM;
        cmd.pos = prev_free ? pick : pick + rac_pkg::IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rac_pkg::ST_IDLE;
      ready    <= 1'b0;
      count    <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rac_pkg::ST_INIT) begin
        ready <= 1'b1;
        count <= rac_pkg::CNT_W'(1);
        total <= init_total;
      end
      if (state == rac_pkg::ST_INS) begin
        count <= count + rac_pkg::CNT_W'(1);
      end
      if (state == rac_pkg::ST_REMA || state == rac_pkg::ST_REMB) begin
        count <= count - rac_pkg::CNT_W'(1);
      end
      if (state == rac_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request and scan data path
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= rac_pkg::opcode_t'(s_tuser[1:0]);
      style      <= rac_pkg::fit_t'(s_tuser[3:2]);
      size_r     <= in_round8;
      off_r      <= s_tdata[61:42];
      init_total <= rac_pkg::TOT_W'(tot_round);
      idx        <= '0;
      found      <= 1'b0;
      res_offset <= '0;
      res_valid  <= 1'b0;
      case (rac_pkg::opcode_t'(s_tuser[1:0]))
        rac_pkg::OP_INIT:  res_status <= (s_tdata[20:0] == '0 || ready
                             || tot_round > rac_pkg::SIZE_W'(rac_pkg::REGION_MAX_BYTES))
                             ? rac_pkg::STS_BAD_ARGS : rac_pkg::STS_OK;
        rac_pkg::OP_ALLOC: res_status <= rac_pkg::STS_NO_SPACE;
        rac_pkg::OP_FREE:  res_status <= s_tuser[4] ? rac_pkg::STS_OK
                             : rac_pkg::STS_BAD_POINTER;
        default:           res_status <= rac_pkg::STS_BAD_ARGS;
      endcase
    end
    if (state == rac_pkg::ST_SCAN) begin
      idx <= idx + rac_pkg::IDX_W'(1);
      if (op == rac_pkg::OP_ALLOC && fit_take) begin
        found      <= 1'b1;
        pick       <= idx;
        pick_start <= head.start;
        psize      <= blk_size;
      end
      if (op == rac_pkg::OP_FREE && free_hit) begin
        found     <= 1'b1;
        pick      <= idx;
        prev_free <= (idx != '0) && tail.free;
        next_free <= has_next && second.free;
      end
    end
    if (state == rac_pkg::ST_MARK) begin
      res_status <= rac_pkg::STS_OK;
      res_offset <= rac_pkg::ADDR_W'(pick_start + rac_pkg::ADDR_W'(rac_pkg::HEADER_BYTES));
      res_valid  <= 1'b1;
    end
    if (state == rac_pkg::ST_FMARK) begin
      res_status <= rac_pkg::STS_OK;
    end
    if (state == rac_pkg::ST_DONE && out_free) begin
      m_tdata <= {{(24 - rac_pkg::ADDR_W){1'b0}}, res_offset};
      m_tuser <= {res_valid, res_status};
    end
  end

  // Table never holds more entries than there are cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rac_pkg::CNT_W'(rac_pkg::MAX_BLOCKS))
    else $error("block count exceeds table size");

  // A grant always comes with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == rac_pkg::STS_OK))
    else $error("grant with failing status");

  // A split adds exactly one entry
  a_split_count: assert property (@(posedge clk) disable iff (rst)
    (state == rac_pkg::ST_INS) |=> (count == $past(count) + rac_pkg::CNT_W'(1)))
    else $error("split did not grow the table");

  // Once the region is set up it stays set up
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    ready |=> ready)
    else $error("region lost its setup");

  // A merge never empties a live table
  a_merge_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == rac_pkg::ST_REMA || state == rac_pkg::ST_REMB) |-> (count > rac_pkg::CNT_W'(1)))
    else $error("merge on a single-entry table");

endmodule
